[hdl/i2c_mbe_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Types, codes and segment tables shared by the bit engine's modules.
// ----------------------------------------------------------------------------
package i2c_mbe_pkg;

	// Command codes carried in the opcode field.
	typedef enum logic [2:0] {
		OP_START   = 3'd0,
		OP_RESTART = 3'd1,
		OP_STOP    = 3'd2,
		OP_WRITE   = 3'd3,
		OP_READ    = 3'd4
	} opcode_t;

	localparam int          HP_W             = 16;
	localparam int          PHASE_W          = 5;
	localparam logic [HP_W-1:0]    HALF_PERIOD_RESET = 16'd250;
	localparam logic [PHASE_W-1:0] PHASE_IDLE   = 5'd0;
	localparam logic [PHASE_W-1:0] PHASE_LAST   = 5'd19;
	localparam logic [7:0]  TOP_BIT          = 8'h80;

	// Line levels, {scl, sda}; a one releases the line.
	localparam logic [1:0] LV_BOTH_LOW = 2'b00;
	localparam logic [1:0] LV_SDA_REL  = 2'b01;
	localparam logic [1:0] LV_SCL_REL  = 2'b10;
	localparam logic [1:0] LV_BOTH_REL = 2'b11;

	// One command beat.
	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] opcode;
		logic [7:0] write_data;
		logic       send_ack;
		logic       sda_in;
	} cmd_beat_t;

	// One result beat.
	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       ack_received;
	} res_beat_t;

	// Sequencer status seen by the top level.
	typedef struct packed {
		logic               idle;
		logic [PHASE_W-1:0] phase;
	} seq_stat_t;

	// Number of segments in each command's sequence.
	function automatic logic [PHASE_W-1:0] seg_total(input opcode_t cmd);
		case (cmd)
			OP_START:   seg_total = 5'd2;
			OP_RESTART: seg_total = 5'd4;
			OP_STOP:    seg_total = 5'd6;
			OP_WRITE:   seg_total = 5'd18;
			default:    seg_total = 5'd19;
		endcase
	endfunction

	// Line levels applied on the completion tick.
	function automatic logic [1:0] final_levels(input opcode_t cmd);
		case (cmd)
			OP_STOP:  final_levels = LV_BOTH_REL;
			OP_WRITE: final_levels = LV_SDA_REL;
			OP_READ:  final_levels = LV_SDA_REL;
			default:  final_levels = LV_BOTH_LOW;
		endcase
	endfunction

	// Line levels held during one segment of a sequence.
	function automatic logic [1:0] seg_levels(
		input opcode_t            cmd,
		input logic [PHASE_W-1:0] seg,
		input logic [1:0]         prev,
		input logic [7:0]         shift,
		input logic               ack_choice
	);
		logic [7:0] sh;
		logic       a;
		sh = shift << seg[3:1];
		a  = ~ack_choice;
		case (cmd)
			OP_START: begin
				seg_levels = (seg == 5'd0) ? {prev[1], 1'b0} : LV_BOTH_LOW;
			end
			OP_RESTART: begin
				if (seg == 5'd0)      seg_levels = {prev[1], 1'b1};
				else if (seg == 5'd1) seg_levels = LV_BOTH_REL;
				else if (seg == 5'd2) seg_levels = LV_SCL_REL;
				else                  seg_levels = LV_BOTH_LOW;
			end
			OP_STOP: begin
				if (seg == 5'd0)      seg_levels = {1'b0, prev[0]};
				else if (seg == 5'd1) seg_levels = LV_BOTH_LOW;
				else if (seg == 5'd2) seg_levels = LV_SCL_REL;
				else                  seg_levels = LV_BOTH_REL;
			end
			OP_WRITE: begin
				if (seg < 5'd16)       seg_levels = {seg[0], |(sh & TOP_BIT)};
				else if (seg == 5'd16) seg_levels = LV_SDA_REL;
				else                   seg_levels = LV_BOTH_REL;
			end
			default: begin
				if (seg < 5'd16)       seg_levels = seg[0] ? LV_SDA_REL : LV_BOTH_REL;
				else if (seg == 5'd17) seg_levels = {1'b1, a};
				else                   seg_levels = {1'b0, a};
			end
		endcase
	endfunction

endpackage

[hdl/i2c_mbe_cmd_if.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine command channel
// Valid/ready channel that carries one command beat per bus tick.
// ----------------------------------------------------------------------------
interface i2c_mbe_cmd_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [2:0] opcode;
	logic [7:0] write_data;
	logic       send_ack;
	logic       sda_in;

	modport source (
		output valid, cmd_valid, opcode, write_data, send_ack, sda_in,
		input  ready
	);
	modport sink (
		input  valid, cmd_valid, opcode, write_data, send_ack, sda_in,
		output ready
	);
endinterface

[hdl/i2c_mbe_res_if.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine result channel
// Valid/ready channel that carries one result beat per bus tick.
// ----------------------------------------------------------------------------
interface i2c_mbe_res_if;
	logic       valid;
	logic       ready;
	logic       scl_release;
	logic       sda_release;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_byte;
	logic       ack_received;

	modport source (
		output valid, scl_release, sda_release, busy_res, done_res, read_byte,
		       ack_received,
		input  ready
	);
	modport sink (
		input  valid, scl_release, sda_release, busy_res, done_res, read_byte,
		       ack_received,
		output ready
	);
endinterface

[hdl/i2c_mbe_seq.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine sequencer
// Holds the bus state and works out the next state and the result beat for
// each accepted command beat in one pass of logic.
// ----------------------------------------------------------------------------
module i2c_mbe_seq
	import i2c_mbe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [HP_W-1:0]   cfg_wdata,
	input  logic              step,
	input  cmd_beat_t         beat,
	output res_beat_t         res_nxt,
	output seq_stat_t         stat
);

	logic [HP_W-1:0]    half_period_q;
	logic [PHASE_W-1:0] phase_q;
	opcode_t            cmd_q;
	logic [7:0]         shift_q;
	logic [HP_W-1:0]    hold_q;
	logic               ack_flag_q;
	logic [1:0]         lines_q;
	logic               ack_choice_q;
	logic [7:0]         read_res_q;

	logic [HP_W-1:0]    hp;
	logic [PHASE_W-1:0] n_phase;
	opcode_t            n_cmd;
	logic [7:0]         n_shift;
	logic [HP_W-1:0]    n_hold;
	logic               n_ack_flag;
	logic [1:0]         n_lines;
	logic               n_ack_choice;
	logic [7:0]         n_read_res;
	logic               enter;
	logic               busy;
	logic               done;
	logic [PHASE_W-1:0] seg;
	logic [PHASE_W-1:0] seg_cur;

	// Next state for one tick.
	always_comb begin
		hp           = (half_period_q == '0) ? {{(HP_W-1){1'b0}}, 1'b1} : half_period_q;
		n_phase      = phase_q;
		n_cmd        = cmd_q;
		n_shift      = shift_q;
		n_hold       = hold_q;
		n_ack_flag   = ack_flag_q;
		n_lines      = lines_q;
		n_ack_choice = ack_choice_q;
		n_read_res   = read_res_q;
		enter        = 1'b0;
		busy         = 1'b0;
		done         = 1'b0;
		seg          = '0;

		if (phase_q == PHASE_IDLE) begin
			if (beat.cmd_valid && (beat.opcode <= OP_READ)) begin
				n_cmd        = opcode_t'(beat.opcode);
				n_ack_choice = beat.send_ack;
				n_shift      = (beat.opcode == OP_WRITE) ? beat.write_data : 8'd0;
				enter        = 1'b1;
				busy         = 1'b1;
			end
		end else if (hold_q >= hp) begin
			if (phase_q >= seg_total(cmd_q)) begin
				// Sequence complete: apply the final levels.
				n_lines = final_levels(cmd_q);
				if (cmd_q == OP_READ) begin
					n_read_res = shift_q;
				end
				n_phase = PHASE_IDLE;
				n_hold  = '0;
				done    = 1'b1;
			end else begin
				enter = 1'b1;
				seg   = phase_q;
				busy  = 1'b1;
			end
		end else begin
			n_hold = hold_q + 16'd1;
			busy   = 1'b1;
		end

		// Start of a new segment.
		if (enter) begin
			n_phase = seg + 5'd1;
			n_hold  = {{(HP_W-1){1'b0}}, 1'b1};
			n_lines = seg_levels(n_cmd, seg, lines_q, n_shift, n_ack_choice);
		end

		// Sample SDA on the last tick of a segment.
		seg_cur = n_phase - 5'd1;
		if (busy && (n_hold == hp)) begin
			if ((n_cmd == OP_WRITE) && (seg_cur == 5'd17)) begin
				n_ack_flag = ~beat.sda_in;
			end else if ((n_cmd == OP_READ) && (seg_cur < 5'd16) && !seg_cur[0]) begin
				n_shift = {n_shift[6:0], beat.sda_in};
			end
		end
	end

	// Result beat for this tick.
	always_comb begin
		res_nxt.scl_release  = n_lines[1];
		res_nxt.sda_release  = n_lines[0];
		res_nxt.busy_res     = busy;
		res_nxt.done_res     = done;
		res_nxt.read_byte    = n_read_res;
		res_nxt.ack_received = n_ack_flag;
	end

	assign stat.idle  = (phase_q == PHASE_IDLE);
	assign stat.phase = phase_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_we) begin
			half_period_q <= cfg_wdata;
		end
	end

	// Sequencer state, advanced once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PHASE_IDLE;
			cmd_q        <= OP_START;
			shift_q      <= '0;
			hold_q       <= '0;
			ack_flag_q   <= 1'b0;
			lines_q      <= LV_BOTH_REL;
			ack_choice_q <= 1'b0;
			read_res_q   <= '0;
		end else if (step) begin
			phase_q      <= n_phase;
			cmd_q        <= n_cmd;
			shift_q      <= n_shift;
			hold_q       <= n_hold;
			ack_flag_q   <= n_ack_flag;
			lines_q      <= n_lines;
			ack_choice_q <= n_ack_choice;
			read_res_q   <= n_read_res;
		end
	end

endmodule

[hdl/i2c_mbe_outreg.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine result register
// Holds one result beat until the sink takes it, so that a new command beat
// can be taken in the same cycle as the held one leaves.
// ----------------------------------------------------------------------------
module i2c_mbe_outreg
	import i2c_mbe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  res_beat_t         res_nxt,
	output logic              can_take,
	i2c_mbe_res_if.source     res
);

	logic      valid_q;
	res_beat_t beat_q;

	// Room for a new beat when empty or when the held one leaves now.
	assign can_take = !valid_q || res.ready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (step) begin
			beat_q <= res_nxt;
		end
	end

	assign res.valid        = valid_q;
	assign res.scl_release  = beat_q.scl_release;
	assign res.sda_release  = beat_q.sda_release;
	assign res.busy_res     = beat_q.busy_res;
	assign res.done_res     = beat_q.done_res;
	assign res.read_byte    = beat_q.read_byte;
	assign res.ack_received = beat_q.ack_received;

endmodule

[hdl/i2c_master_bit_engine.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine
// Open-drain I2C master sequencer that advances one bus tick per command beat
// and returns one result beat per tick.
//
//   channel   dir   handshake      carries
//   cmd       in    valid/ready    command, write byte, ack choice, SDA sample
//   res       out   valid/ready    SCL/SDA release, busy, done, read byte, ack
//   cfg       in    cfg_we         half_period (bus half bit time in ticks)
//
// One command beat is taken per cycle while the result register has room;
// its result beat appears in the result register on the next cycle, set by a
// single pass through the sequencer. Reset clears the sequencer to idle with
// both lines released and sets half_period to 250. A held result beat blocks
// a new command beat only if the sink is not taking it in the same cycle.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine
	import i2c_mbe_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [HP_W-1:0] cfg_wdata,
	i2c_mbe_cmd_if.sink     cmd,
	i2c_mbe_res_if.source   res
);

	logic      step;
	logic      can_take;
	cmd_beat_t beat;
	res_beat_t res_nxt;
	seq_stat_t stat;

	// Command handshake.
	assign cmd.ready = can_take;
	assign step      = cmd.valid && cmd.ready;

	assign beat.cmd_valid  = cmd.cmd_valid;
	assign beat.opcode     = cmd.opcode;
	assign beat.write_data = cmd.write_data;
	assign beat.send_ack   = cmd.send_ack;
	assign beat.sda_in     = cmd.sda_in;

	i2c_mbe_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.beat      (beat),
		.res_nxt   (res_nxt),
		.stat      (stat)
	);

	i2c_mbe_outreg u_outreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.res_nxt  (res_nxt),
		.can_take (can_take),
		.res      (res)
	);

	// The phase never runs past the longest sequence.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.phase <= PHASE_LAST)
		else $error("sequencer phase out of range");

	// A valid command taken while idle starts a sequence at once.
	a_cmd_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && stat.idle && cmd.cmd_valid && (cmd.opcode <= OP_READ))
		|=> (res.valid && res.busy_res))
		else $error("accepted command did not start a sequence");

	// A tick taken mid-sequence reports exactly one of busy and done.
	a_busy_or_done: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !stat.idle) |=> (res.valid && (res.busy_res != res.done_res)))
		else $error("busy and done disagree during a sequence");

	// A completion tick leaves the sequencer idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_nxt.done_res) |=> stat.idle)
		else $error("sequencer not idle after completion");

endmodule
